/* rtl/core/dtr_pkg.sv */
`timescale 1ns / 1ps
package dtr_pkg;

  localparam int SIG_ENTRIES = 256;
  localparam int SIG_IW = $clog2(SIG_ENTRIES);

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_TRAIN = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [2:0] BIAS_SELECT = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_RDATA,
    ST_RD,
    ST_NET,
    ST_SUM,
    ST_ACT,
    ST_DER,
    ST_G,
    ST_GX,
    ST_LR,
    ST_WB,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         sel_class;
    logic [2:0]         sel_feature;
    logic signed [15:0] weight_value;
    logic signed [15:0] feature_0;
    logic signed [15:0] feature_1;
    logic signed [15:0] feature_2;
    logic signed [15:0] feature_3;
    logic signed [15:0] target_0;
    logic signed [15:0] target_1;
    logic signed [15:0] target_2;
    logic signed [15:0] target_3;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        sample_error;
    logic signed [15:0] read_weight;
    logic               error_saturated;
  } out_item_t;

  typedef struct packed {
    logic ld_w;
    logic ld_gx;
    logic ld_q;
  } lane_ctl_t;

  typedef struct packed {
    logic ld_net;
    logic ld_f;
    logic ld_de;
    logic ld_g;
  } merge_ctl_t;

  typedef logic signed [15:0] sig_tab_t [SIG_ENTRIES];

  function automatic logic ovf16(input logic signed [31:0] v);
    return (v > 32'sd32767) || (v < -32'sd32768);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
    logic signed [15:0] r;
    if (v > 32'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -32'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Magnitude of tanh(a/2) in Q4.12, evaluated while the table is built.
  function automatic logic [15:0] half_tanh_mag(input logic [31:0] a);
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t3;
    logic [63:0] t4;
    logic [63:0] u;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] q;
    logic [63:0] rem;
    int k;
    int b;
    one = 64'd1 << 31;
    t = {32'd0, a} << 11;
    t2 = (t * t) >> 31;
    t3 = (t2 * t) >> 31;
    t4 = (t3 * t) >> 31;
    u = one - t + (t2 >> 1) - t3 / 64'd6 + t4 / 64'd24;
    for (k = 0; k < 8; k++) begin
      u = (u * u + (64'd1 << 30)) >> 31;
    end
    num = ((one - u) << 12) + ((one + u) >> 1);
    den = one + u;
    q = '0;
    rem = '0;
    for (b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem = rem - den;
        q[b] = 1'b1;
      end
    end
    return q[15:0];
  endfunction

  function automatic sig_tab_t build_table();
    sig_tab_t tab;
    int i;
    int x;
    int ax;
    logic [15:0] m;
    for (i = 0; i < SIG_ENTRIES; i++) begin
      x = -32768 + (i * 65536) / SIG_ENTRIES;
      ax = (x < 0) ? -x : x;
      m = half_tanh_mag(32'(ax));
      tab[i] = (x < 0) ? -m : m;
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_table();

endpackage

/* rtl/core/multi_class_delta_rule_trainer_unit.sv */
`timescale 1ns / 1ps
// Channel  Direction  Handshake          Payload
// in       input      in_valid/in_stall  dtr_pkg::in_item_t
// out      output     out_valid/out_stall dtr_pkg::out_item_t
// cfg      input      cfg_we             cfg_addr, cfg_data
// A write passes through the command state and a read also through the read-data state;
// a train item makes one pass per class in use through the weight memories and the merging stage.
// Feature lanes work in parallel inside each class pass.
// After reset every stored weight and bias reads as zero through per-entry valid bits.
// A finished result waits in the output register; a new item is taken while it waits.
module multi_class_delta_rule_trainer_unit #(
  parameter int MAX_FEATURES = 4,
  parameter int MAX_CLASSES = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dtr_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dtr_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [15:0]        cfg_data
);

  localparam int NLANE = (MAX_FEATURES < 4) ? MAX_FEATURES : 4;
  localparam int NCLSH = (MAX_CLASSES < 4) ? MAX_CLASSES : 4;
  localparam int NCOL = MAX_FEATURES + 1;
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW = $clog2(NCOL);

  localparam logic [1:0] REG_LR = 2'd0;
  localparam logic [1:0] REG_NF = 2'd1;
  localparam logic [1:0] REG_NC = 2'd2;

  dtr_pkg::state_t state_r, state_nxt;

  logic [15:0] lr_r;
  logic [2:0]  nfeat_r;
  logic [2:0]  ncls_r;
  logic [2:0]  nf;
  logic [2:0]  nc;

  logic [1:0]         cmd_r;
  logic [1:0]         cls_r;
  logic [2:0]         col_r;
  logic signed [15:0] wv_r;
  logic signed [15:0] x_r [4];
  logic signed [15:0] t_r [4];
  logic [2:0]         cnt_r;

  logic               sel_ok;
  logic [CW-1:0]      sel_col;
  logic [AW-1:0]      addr;
  logic [NCOL-1:0]    ram_we;
  logic [15:0]        ram_wd [NCOL];
  logic [15:0]        ram_q [NCOL];
  logic signed [15:0] rq_eff [NCOL];
  logic               vld_r [NCOL][MAX_CLASSES];
  logic [NCOL-1:0]    rd_vld_r;

  dtr_pkg::lane_ctl_t  lane_ctl;
  dtr_pkg::merge_ctl_t merge_ctl;

  logic signed [31:0] prod [NLANE];
  logic signed [15:0] w_new [NLANE];
  logic [NLANE-1:0]   lsat;
  logic signed [18:0] g;
  logic signed [17:0] e;

  logic signed [15:0] b_r;
  logic signed [35:0] qb_r;
  logic signed [35:0] qb_rnd;
  logic signed [19:0] bdelta;
  logic signed [21:0] bs;
  logic signed [15:0] b_new;
  logic               b_sat;
  logic signed [35:0] ee;
  logic [35:0]        ee_rnd;
  logic [20:0]        esum_r;
  logic               flag_r;
  logic signed [15:0] res_rd_r;
  logic               wb_sat;
  logic               accept;
  logic               out_free;
  logic               err_big;

  dtr_pkg::out_item_t out_r;
  logic               out_valid_r;

  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    if (nfeat_r == 3'd0) begin
      nf = 3'd1;
    end else if (nfeat_r > 3'(NLANE)) begin
      nf = 3'(NLANE);
    end else begin
      nf = nfeat_r;
    end
    if (ncls_r == 3'd0) begin
      nc = 3'd1;
    end else if (ncls_r > 3'(NCLSH)) begin
      nc = 3'(NCLSH);
    end else begin
      nc = ncls_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= 16'd655;
      nfeat_r <= 3'd4;
      ncls_r <= 3'd4;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_LR: lr_r <= cfg_data;
        REG_NF: nfeat_r <= cfg_data[2:0];
        REG_NC: ncls_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dtr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.command == dtr_pkg::CMD_TRAIN) ? dtr_pkg::ST_RD
                                                               : dtr_pkg::ST_CMD;
        end
      end
      dtr_pkg::ST_CMD:
        state_nxt = (cmd_r == dtr_pkg::CMD_READ) ? dtr_pkg::ST_RDATA : dtr_pkg::ST_DONE;
      dtr_pkg::ST_RDATA: state_nxt = dtr_pkg::ST_DONE;
      dtr_pkg::ST_RD:    state_nxt = dtr_pkg::ST_NET;
      dtr_pkg::ST_NET:   state_nxt = dtr_pkg::ST_SUM;
      dtr_pkg::ST_SUM:   state_nxt = dtr_pkg::ST_ACT;
      dtr_pkg::ST_ACT:   state_nxt = dtr_pkg::ST_DER;
      dtr_pkg::ST_DER:   state_nxt = dtr_pkg::ST_G;
      dtr_pkg::ST_G:     state_nxt = dtr_pkg::ST_GX;
      dtr_pkg::ST_GX:    state_nxt = dtr_pkg::ST_LR;
      dtr_pkg::ST_LR:    state_nxt = dtr_pkg::ST_WB;
      dtr_pkg::ST_WB:
        state_nxt = (cnt_r == nc - 3'd1) ? dtr_pkg::ST_DONE : dtr_pkg::ST_RD;
      dtr_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = dtr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dtr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != dtr_pkg::ST_IDLE);
    lane_ctl.ld_w = (state_r == dtr_pkg::ST_NET);
    lane_ctl.ld_gx = (state_r == dtr_pkg::ST_GX);
    lane_ctl.ld_q = (state_r == dtr_pkg::ST_LR);
    merge_ctl.ld_net = (state_r == dtr_pkg::ST_SUM);
    merge_ctl.ld_f = (state_r == dtr_pkg::ST_ACT);
    merge_ctl.ld_de = (state_r == dtr_pkg::ST_DER);
    merge_ctl.ld_g = (state_r == dtr_pkg::ST_G);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dtr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_data.command;
      cls_r <= in_data.sel_class;
      col_r <= in_data.sel_feature;
      wv_r <= in_data.weight_value;
      x_r[0] <= in_data.feature_0;
      x_r[1] <= in_data.feature_1;
      x_r[2] <= in_data.feature_2;
      x_r[3] <= in_data.feature_3;
      t_r[0] <= in_data.target_0;
      t_r[1] <= in_data.target_1;
      t_r[2] <= in_data.target_2;
      t_r[3] <= in_data.target_3;
    end
  end

  always_comb begin
    sel_ok = (32'(cls_r) < MAX_CLASSES) &&
             ((col_r == dtr_pkg::BIAS_SELECT) || (32'(col_r) < MAX_FEATURES));
    sel_col = (col_r == dtr_pkg::BIAS_SELECT) ? CW'(MAX_FEATURES) : CW'(col_r);
    addr = (state_r == dtr_pkg::ST_CMD) ? AW'(cls_r) : AW'(cnt_r);
  end

  for (genvar k = 0; k < NCOL; k++) begin : g_col
    logic train_we;
    if (k < NLANE) begin : g_lane_col
      assign train_we = (3'(k) < nf);
      assign ram_wd[k] = (state_r == dtr_pkg::ST_WB) ? w_new[k] : wv_r;
    end else if (k == MAX_FEATURES) begin : g_bias_col
      assign train_we = 1'b1;
      assign ram_wd[k] = (state_r == dtr_pkg::ST_WB) ? b_new : wv_r;
    end else begin : g_spare_col
      assign train_we = 1'b0;
      assign ram_wd[k] = wv_r;
    end

    assign ram_we[k] = ((state_r == dtr_pkg::ST_CMD) && (cmd_r == dtr_pkg::CMD_WRITE) &&
                        sel_ok && (sel_col == CW'(k))) ||
                       ((state_r == dtr_pkg::ST_WB) && train_we);

    dtr_ram #(
      .WIDTH(16),
      .DEPTH(MAX_CLASSES)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[k]),
      .addr (addr),
      .wdata(ram_wd[k]),
      .rdata(ram_q[k])
    );

    assign rq_eff[k] = rd_vld_r[k] ? ram_q[k] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NCOL; k++) begin
        for (int c = 0; c < MAX_CLASSES; c++) begin
          vld_r[k][c] <= 1'b0;
        end
      end
      rd_vld_r <= '0;
    end else begin
      for (int k = 0; k < NCOL; k++) begin
        if (ram_we[k]) begin
          vld_r[k][addr] <= 1'b1;
        end
        rd_vld_r[k] <= vld_r[k][addr];
      end
    end
  end

  for (genvar j = 0; j < NLANE; j++) begin : g_lane
    dtr_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .active(3'(j) < nf),
      .x     (x_r[j]),
      .w_rd  (rq_eff[j]),
      .g     (g),
      .lr    (lr_r),
      .prod  (prod[j]),
      .w_new (w_new[j]),
      .sat   (lsat[j])
    );
  end

  dtr_merge #(
    .NLANE(NLANE)
  ) u_merge (
    .clk   (clk),
    .ctl   (merge_ctl),
    .prods (prod),
    .bias  (b_r),
    .target(t_r[cnt_r[1:0]]),
    .g     (g),
    .e     (e)
  );

  always_comb begin
    qb_rnd = qb_r + 36'sd32768 - 36'(qb_r[35]);
    bdelta = qb_rnd[35:16];
    bs = 22'(b_r) + 22'(bdelta);
    b_new = dtr_pkg::sat16(32'(bs));
    b_sat = dtr_pkg::ovf16(32'(bs));
    ee = e * e;
    ee_rnd = ee + 36'd4096;
    wb_sat = b_sat;
    for (int j = 0; j < NLANE; j++) begin
      wb_sat = wb_sat | (lsat[j] && (3'(j) < nf));
    end
    err_big = (esum_r > 21'd65535);
  end

  always_ff @(posedge clk) begin
    if (state_r == dtr_pkg::ST_NET) begin
      b_r <= rq_eff[MAX_FEATURES];
    end
    if (state_r == dtr_pkg::ST_LR) begin
      qb_r <= $signed({1'b0, lr_r}) * g;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cnt_r <= '0;
      esum_r <= '0;
      flag_r <= 1'b0;
      res_rd_r <= '0;
    end else begin
      if (state_r == dtr_pkg::ST_WB) begin
        cnt_r <= cnt_r + 3'd1;
        flag_r <= flag_r | wb_sat;
      end
      if (state_r == dtr_pkg::ST_GX) begin
        esum_r <= esum_r + ee_rnd[33:13];
      end
      if ((state_r == dtr_pkg::ST_RDATA) && sel_ok) begin
        res_rd_r <= rq_eff[sel_col];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == dtr_pkg::ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == dtr_pkg::ST_DONE) && out_free) begin
      out_r.sample_error <= err_big ? 16'hffff : esum_r[15:0];
      out_r.read_weight <= res_rd_r;
      out_r.error_saturated <= flag_r | err_big;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_r;

`ifndef NO_ASSERTIONS
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == dtr_pkg::ST_DONE))
    else $error("result raised outside the done state");

  a_class_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtr_pkg::ST_WB) |-> (cnt_r < nc))
    else $error("class counter beyond classes in use");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == dtr_pkg::ST_IDLE) |-> (ram_we == '0))
    else $error("store written while idle");
`endif

endmodule

/* rtl/core/dtr_ram.sv */
`timescale 1ns / 1ps
module dtr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                      wdata,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata <= mem_r[addr];
  end

endmodule

/* rtl/core/dtr_lane.sv */
`timescale 1ns / 1ps
module dtr_lane (
  input  logic                clk,
  input  dtr_pkg::lane_ctl_t  ctl,
  input  logic                active,
  input  logic signed [15:0]  x,
  input  logic signed [15:0]  w_rd,
  input  logic signed [18:0]  g,
  input  logic [15:0]         lr,
  output logic signed [31:0]  prod,
  output logic signed [15:0]  w_new,
  output logic                sat
);

  logic signed [15:0] w_r;
  logic signed [31:0] prod_r;
  logic signed [34:0] p_r;
  logic signed [51:0] q_r;
  logic signed [51:0] q_rnd;
  logic signed [23:0] delta;
  logic signed [25:0] ws;

  always_ff @(posedge clk) begin
    if (ctl.ld_w) begin
      w_r <= w_rd;
      prod_r <= active ? w_rd * x : 32'sd0;
    end
    if (ctl.ld_gx) begin
      p_r <= g * x;
    end
    if (ctl.ld_q) begin
      q_r <= $signed({1'b0, lr}) * p_r;
    end
  end

  always_comb begin
    q_rnd = q_r + 52'sd134217728 - 52'(q_r[51]);
    delta = q_rnd[51:28];
    ws = 26'(w_r) + 26'(delta);
    w_new = dtr_pkg::sat16(32'(ws));
    sat = dtr_pkg::ovf16(32'(ws));
  end

  assign prod = prod_r;

endmodule

/* rtl/core/dtr_merge.sv */
`timescale 1ns / 1ps
module dtr_merge #(
  parameter int NLANE = 4
) (
  input  logic                clk,
  input  dtr_pkg::merge_ctl_t ctl,
  input  logic signed [31:0]  prods [NLANE],
  input  logic signed [15:0]  bias,
  input  logic signed [15:0]  target,
  output logic signed [18:0]  g,
  output logic signed [17:0]  e
);

  logic signed [35:0] acc;
  logic signed [35:0] acc_rnd;
  logic signed [23:0] net24;
  logic signed [15:0] net_r;
  logic [15:0]        net_off;
  logic [28:0]        idx_prod;
  logic [dtr_pkg::SIG_IW-1:0] idx;
  logic signed [15:0] f_r;
  logic signed [31:0] ff;
  logic [31:0]        ff_rnd;
  logic signed [13:0] dd;
  logic signed [12:0] d_r;
  logic signed [17:0] e_r;
  logic signed [30:0] ed;
  logic signed [30:0] ed_rnd;
  logic signed [18:0] g_r;

  always_comb begin
    acc = {{8{bias[15]}}, bias, 12'd0};
    for (int j = 0; j < NLANE; j++) begin
      acc = acc + 36'(prods[j]);
    end
    acc_rnd = acc + 36'sd2048 - 36'(acc[35]);
    net24 = acc_rnd[35:12];
    net_off = {~net_r[15], net_r[14:0]};
    idx_prod = 29'(net_off) * 29'(dtr_pkg::SIG_ENTRIES);
    idx = dtr_pkg::SIG_IW'(idx_prod >> 16);
    ff = f_r * f_r;
    ff_rnd = ff + 32'd2048;
    dd = 14'sd4096 - 14'(ff_rnd[31:12]);
    ed = e_r * d_r;
    ed_rnd = ed + 31'sd2048 - 31'(ed[30]);
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_net) begin
      net_r <= dtr_pkg::sat16(32'(net24));
    end
    if (ctl.ld_f) begin
      f_r <= dtr_pkg::SIG_TABLE[idx];
    end
    if (ctl.ld_de) begin
      d_r <= dd[13:1];
      e_r <= 18'(target) - 18'(f_r);
    end
    if (ctl.ld_g) begin
      g_r <= ed_rnd[30:12];
    end
  end

  assign g = g_r;
  assign e = e_r;

endmodule

/* tb/tb_multi_class_delta_rule_trainer_unit.sv */
`timescale 1ns / 1ps
module tb_multi_class_delta_rule_trainer_unit;

  localparam logic [1:0] REG_LEARNING_RATE = 2'd0;
  localparam logic [1:0] REG_FEATURES = 2'd1;
  localparam logic [1:0] REG_CLASSES = 2'd2;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;

  class trainer_scoreboard;
    dtr_pkg::out_item_t expected_q[$];
    logic signed [15:0] weights[16];
    logic signed [15:0] biases[4];
    logic signed [15:0] tanh_table[256];
    int unsigned rate;
    int unsigned nfeat;
    int unsigned nclass;
    int errors;

    function new();
      int i;
      int x;
      int m;
      rate = 655;
      nfeat = 4;
      nclass = 4;
      errors = 0;
      for (i = 0; i < 16; i++) weights[i] = 0;
      for (i = 0; i < 4; i++) biases[i] = 0;
      for (i = 0; i < 256; i++) begin
        x = -32768 + i * 256;
        m = half_tanh(x < 0 ? -x : x);
        tanh_table[i] = 16'((x < 0) ? -m : m);
      end
    endfunction

    function int half_tanh(int a);
      longint unsigned one;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned t3;
      longint unsigned t4;
      longint unsigned u;
      int k;
      one = 64'd1 << 31;
      t = longint'(a) << 11;
      t2 = (t * t) >> 31;
      t3 = (t2 * t) >> 31;
      t4 = (t3 * t) >> 31;
      u = one - t + (t2 >> 1) - t3 / 6 + t4 / 24;
      for (k = 0; k < 8; k++) u = (u * u + (64'd1 << 30)) >> 31;
      return int'((((one - u) << 12) + ((one + u) >> 1)) / (one + u));
    endfunction

    function longint round_shift(longint v, int s);
      longint h;
      h = longint'(1) << (s - 1);
      if (v >= 0) return (v + h) >>> s;
      return -((-v + h) >>> s);
    endfunction

    function longint saturate(longint v, ref bit flag);
      if (v > 32767) begin
        flag = 1;
        return 32767;
      end
      if (v < -32768) begin
        flag = 1;
        return -32768;
      end
      return v;
    endfunction

    function int unsigned clamp(int unsigned v);
      if (v < 1) return 1;
      return (v > 4) ? 4 : v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      if (idx == REG_LEARNING_RATE) rate = val;
      else if (idx == REG_FEATURES) nfeat = val[2:0];
      else if (idx == REG_CLASSES) nclass = val[2:0];
    endfunction

    function void note_item(dtr_pkg::in_item_t it);
      dtr_pkg::out_item_t r;
      int unsigned nf;
      int unsigned nc;
      longint x[4];
      longint t[4];
      longint acc;
      longint net;
      longint f;
      longint d;
      longint e;
      longint g;
      longint esum;
      bit flag;
      bit dummy;
      int c;
      int j;
      r = '0;
      if (it.command == dtr_pkg::CMD_WRITE || it.command == dtr_pkg::CMD_READ) begin
        if (it.sel_feature == dtr_pkg::BIAS_SELECT) begin
          if (it.command == dtr_pkg::CMD_WRITE) biases[it.sel_class] = it.weight_value;
          else r.read_weight = biases[it.sel_class];
        end else if (it.sel_feature < 4) begin
          if (it.command == dtr_pkg::CMD_WRITE)
            weights[it.sel_class * 4 + it.sel_feature] = it.weight_value;
          else r.read_weight = weights[it.sel_class * 4 + it.sel_feature];
        end
      end else if (it.command == dtr_pkg::CMD_TRAIN) begin
        nf = clamp(nfeat);
        nc = clamp(nclass);
        x = '{it.feature_0, it.feature_1, it.feature_2, it.feature_3};
        t = '{it.target_0, it.target_1, it.target_2, it.target_3};
        esum = 0;
        flag = 0;
        for (c = 0; c < nc; c++) begin
          acc = longint'(biases[c]) * 4096;
          for (j = 0; j < nf; j++) acc += longint'(weights[c * 4 + j]) * x[j];
          net = saturate(round_shift(acc, 12), dummy);
          f = tanh_table[(net + 32768) >>> 8];
          d = (4096 - round_shift(f * f, 12)) >>> 1;
          e = t[c] - f;
          g = round_shift(e * d, 12);
          esum += round_shift(e * e, 13);
          for (j = 0; j < nf; j++)
            weights[c * 4 + j] = 16'(saturate(longint'(weights[c * 4 + j]) +
                round_shift(longint'(rate) * g * x[j], 28), flag));
          biases[c] = 16'(saturate(longint'(biases[c]) +
              round_shift(longint'(rate) * g, 16), flag));
        end
        if (esum > 65535) begin
          esum = 65535;
          flag = 1;
        end
        r.sample_error = esum[15:0];
        r.error_saturated = flag;
      end
      expected_q.push_back(r);
    endfunction

    function void check_result(dtr_pkg::out_item_t got);
      dtr_pkg::out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.sample_error !== want.sample_error) begin
        $display("%0t: sample_error expected %0d actual %0d", $time,
                 want.sample_error, got.sample_error);
        errors++;
      end
      if (got.read_weight !== want.read_weight) begin
        $display("%0t: read_weight expected %0d actual %0d", $time,
                 want.read_weight, got.read_weight);
        errors++;
      end
      if (got.error_saturated !== want.error_saturated) begin
        $display("%0t: error_saturated expected %0b actual %0b", $time,
                 want.error_saturated, got.error_saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  dtr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  dtr_pkg::out_item_t out_data;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_data = '0;

  int idle_pct = 0;
  int stall_pct = 0;
  int cycles = 0;
  trainer_scoreboard sb = new();

  multi_class_delta_rule_trainer_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic signed [15:0] pick_value();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return $signed(16'($urandom_range(8192))) - 16'sd4096;
      2: return $signed(16'($urandom_range(2048))) - 16'sd1024;
      3: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return $signed(16'($urandom_range(16384))) - 16'sd8192;
    endcase
  endfunction

  function automatic dtr_pkg::in_item_t random_item();
    dtr_pkg::in_item_t it;
    int sel;
    it = '0;
    it.sel_class = 2'($urandom);
    it.sel_feature = 3'($urandom);
    it.weight_value = pick_value();
    it.feature_0 = pick_value();
    it.feature_1 = pick_value();
    it.feature_2 = pick_value();
    it.feature_3 = pick_value();
    it.target_0 = pick_value();
    it.target_1 = pick_value();
    it.target_2 = pick_value();
    it.target_3 = pick_value();
    sel = $urandom_range(99);
    if (sel < 12) it.command = dtr_pkg::CMD_WRITE;
    else if (sel < 24) it.command = dtr_pkg::CMD_READ;
    else if (sel < 28) it.command = dtr_pkg::CMD_NONE;
    else it.command = dtr_pkg::CMD_TRAIN;
    return it;
  endfunction

  task automatic send_item(dtr_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_data <= it;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_item(it);
  endtask

  task automatic drain();
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic configure(logic [15:0] lr, logic [15:0] nf, logic [15:0] nc);
    in_valid <= 0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(REG_LEARNING_RATE, lr);
    write_reg(REG_FEATURES, nf);
    write_reg(REG_CLASSES, nc);
    cfg_we <= 0;
  endtask

  task automatic send_access(dtr_pkg::cmd_t cmd, int cls, int col,
                             logic signed [15:0] val);
    dtr_pkg::in_item_t it;
    it = random_item();
    it.command = cmd;
    it.sel_class = 2'(cls);
    it.sel_feature = 3'(col);
    it.weight_value = val;
    send_item(it);
  endtask

  task automatic send_sample(logic signed [15:0] xv, logic signed [15:0] tv);
    dtr_pkg::in_item_t it;
    it = random_item();
    it.command = dtr_pkg::CMD_TRAIN;
    it.feature_0 = xv;
    it.feature_1 = -xv;
    it.feature_2 = xv;
    it.feature_3 = xv;
    it.target_0 = tv;
    it.target_1 = -tv;
    it.target_2 = tv;
    it.target_3 = 16'sh7fff;
    send_item(it);
  endtask

  logic [15:0] lr_set[8] = '{16'd655, 16'd65535, 16'd0, 16'd20000,
                             16'd3000, 16'd65535, 16'd9000, 16'd1};
  logic [15:0] nf_set[8] = '{16'd4, 16'd4, 16'd1, 16'd0, 16'd2, 16'd7, 16'd3, 16'd4};
  logic [15:0] nc_set[8] = '{16'd4, 16'd4, 16'd1, 16'd7, 16'd3, 16'd0, 16'd2, 16'd4};

  initial begin
    int p;
    int n;
    int c;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    send_sample(16'sh1000, 16'sh0800);
    send_access(dtr_pkg::CMD_READ, 0, 0, 0);
    send_access(dtr_pkg::CMD_READ, 3, dtr_pkg::BIAS_SELECT, 0);
    send_access(dtr_pkg::CMD_WRITE, 0, 0, 16'sh7fff);
    send_access(dtr_pkg::CMD_WRITE, 1, 3, 16'sh8000);
    send_access(dtr_pkg::CMD_WRITE, 3, dtr_pkg::BIAS_SELECT, 16'sh7fff);
    send_access(dtr_pkg::CMD_WRITE, 2, dtr_pkg::BIAS_SELECT, 16'sh8000);
    send_access(dtr_pkg::CMD_WRITE, 2, 5, 16'sh1234);
    send_access(dtr_pkg::CMD_WRITE, 2, 7, 16'sh4321);
    send_access(dtr_pkg::CMD_READ, 2, 6, 0);
    send_access(dtr_pkg::CMD_NONE, 1, 1, 16'sh5555);
    send_access(dtr_pkg::CMD_READ, 0, 0, 0);
    send_access(dtr_pkg::CMD_READ, 1, 3, 0);
    send_access(dtr_pkg::CMD_READ, 3, dtr_pkg::BIAS_SELECT, 0);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh0000, 16'sh0000);
    send_sample(16'sh7fff, 16'sh7fff);
    send_access(dtr_pkg::CMD_READ, 0, 0, 0);
    send_access(dtr_pkg::CMD_READ, 2, dtr_pkg::BIAS_SELECT, 0);

    for (p = 0; p < 8; p++) begin
      configure(lr_set[p], nf_set[p], nc_set[p]);
      idle_pct = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 3) ? 9 : 52) : 0;
      stall_pct = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 3) ? 9 : 52) : 0;
      for (c = 0; c < 4; c++)
        send_access(dtr_pkg::CMD_WRITE, c, $urandom_range(4),
                    $signed(16'($urandom_range(4096))) - 16'sd2048);
      for (n = 0; n < 100; n++) begin
        if (p == 2 && n == 50) begin
          in_valid <= 0;
          drain();
        end
        send_item(random_item());
      end
    end

    in_valid <= 0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/core/dtr_pkg.sv
rtl/core/dtr_ram.sv
rtl/core/dtr_lane.sv
rtl/core/dtr_merge.sv
rtl/core/multi_class_delta_rule_trainer_unit.sv
tb/tb_multi_class_delta_rule_trainer_unit.sv
